### src/lmx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmx_pkg
// Shared types and constants of the Lamport mutual exclusion node.
// ----------------------------------------------------------------------------
package lmx_pkg;

    localparam int TS_W             = 31;
    localparam int PORT_W           = 16;
    localparam int KEY_W            = TS_W + PORT_W;
    localparam int CNT_W            = 8;
    localparam int QUEUE_DEPTH_DEF  = 16;

    localparam int S_TDATA_W        = 48;
    localparam int M_TDATA_W        = 48;
    localparam int CFG_W            = 16;

    localparam logic [TS_W-1:0]  CLOCK_MAX = {TS_W{1'b1}};
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // command codes
    localparam logic [1:0] CMD_LOCAL   = 2'd0;
    localparam logic [1:0] CMD_PEER    = 2'd1;
    localparam logic [1:0] CMD_REPLY   = 2'd2;
    localparam logic [1:0] CMD_RELEASE = 2'd3;

    // action codes
    localparam logic [1:0] ACT_NONE      = 2'd0;
    localparam logic [1:0] ACT_BROADCAST = 2'd1;
    localparam logic [1:0] ACT_REPLY     = 2'd2;
    localparam logic [1:0] ACT_ENTER     = 2'd3;

    // configuration register indexes
    localparam logic REG_OWN_PORT   = 1'b0;
    localparam logic REG_PEER_COUNT = 1'b1;

    typedef logic [KEY_W-1:0] key_t;

    typedef struct packed {
        logic insert;
        logic pop;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_EXEC  = 3'b010,
        ST_GRANT = 3'b100
    } state_t;

endpackage

### src/lmx_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmx_cell
// One slot of the sorted request chain: compare, shift right on insert,
// shift left on pop.
// ----------------------------------------------------------------------------
module lmx_cell (
    input  logic                aclk,
    input  lmx_pkg::cell_ctrl_t ctrl,
    input  lmx_pkg::key_t       new_key,
    input  logic                occupied,
    input  lmx_pkg::key_t       left_key,
    input  logic                left_greater,
    input  lmx_pkg::key_t       right_key,
    output lmx_pkg::key_t       key,
    output logic                greater
);
    import lmx_pkg::*;

    key_t key_reg;
    key_t key_next;

    // empty slots count as greater so the insert point is the first of them
    assign greater = !occupied || (key_reg > new_key);
    assign key     = key_reg;

    always_comb begin
        key_next = key_reg;
        if (ctrl.insert) begin
            if (greater) begin
                key_next = left_greater ? left_key : new_key;
            end
        end else if (ctrl.pop) begin
            key_next = right_key;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

endmodule

### src/lamport_mutex_node.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lamport_mutex_node
// One node of Lamport mutual exclusion with a sorted chain of request cells.
//
//   channel   dir  tdata                               tuser
//   s_        in   msg_timestamp, msg_port             command
//   m_        out  out_timestamp, out_port, overflow   action
//   cfg_      in   own_port / peer_count write         -
//
// Requests pass through the execute step; replies to this node and releases
// also pass through the grant check that follows it.
// The chain inserts or pops across all cells together.
// aresetn is synchronous: clock, reply count and fill clear at once.
// A held m_ word stalls execute or grant steps that emit one, not input acceptance.
// ----------------------------------------------------------------------------
module lamport_mutex_node #(
    parameter int QUEUE_DEPTH = lmx_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lmx_pkg::S_TDATA_W-1:0] s_tdata,   // msg_timestamp, msg_port, pad
    input  logic [1:0]                    s_tuser,   // command
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lmx_pkg::M_TDATA_W-1:0] m_tdata,   // out_timestamp, out_port,
                                                     // queue_overflow
    output logic [1:0]                    m_tuser,   // action
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [lmx_pkg::CFG_W-1:0]     cfg_wdata
);
    import lmx_pkg::*;

    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    state_t              state_reg, state_next;
    logic [1:0]          cmd_reg;
    logic [TS_W-1:0]     ts_reg;
    logic [PORT_W-1:0]   port_reg;
    logic [TS_W-1:0]     clock_reg, clock_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [PORT_W-1:0]   own_port_reg;
    logic [CNT_W-1:0]    peer_count_reg;

    logic                m_valid_reg, m_valid_next;
    logic [1:0]          m_action_reg, m_action_next;
    logic [TS_W-1:0]     m_ts_reg, m_ts_next;
    logic [PORT_W-1:0]   m_port_reg, m_port_next;
    logic                m_ovf_reg, m_ovf_next;

    cell_ctrl_t          ctrl;
    key_t                new_key;
    key_t                keys [QUEUE_DEPTH];
    logic                greater [QUEUE_DEPTH];

    logic                out_free;
    logic                full;
    logic [TS_W-1:0]     clk_max;
    logic [TS_W-1:0]     clk_inc;
    logic                granted;

    assign s_tready = aresetn && (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_action_reg;
    assign m_tdata  = {m_ovf_reg, m_port_reg, m_ts_reg};

    assign out_free = !m_valid_reg || m_tready;
    assign full     = (fill_reg == FILL_W'(QUEUE_DEPTH));
    assign clk_max  = (cmd_reg == CMD_PEER && ts_reg > clock_reg) ? ts_reg : clock_reg;
    assign clk_inc  = (clk_max == CLOCK_MAX) ? clk_max : clk_max + 1'b1;
    assign new_key  = (cmd_reg == CMD_LOCAL) ? {clk_inc, own_port_reg} : {ts_reg, port_reg};
    assign granted  = (fill_reg != '0) && (count_reg == peer_count_reg)
                      && (keys[0][PORT_W-1:0] == own_port_reg);

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            key_t left_key;
            logic left_greater;
            key_t right_key;
            if (g == 0) begin : g_first
                assign left_key     = '0;
                assign left_greater = 1'b0;
            end else begin : g_inner
                assign left_key     = keys[g-1];
                assign left_greater = greater[g-1];
            end
            if (g == QUEUE_DEPTH - 1) begin : g_last
                assign right_key = keys[g];
            end else begin : g_body
                assign right_key = keys[g+1];
            end
            lmx_cell u_cell (
                .aclk         (aclk),
                .ctrl         (ctrl),
                .new_key      (new_key),
                .occupied     (FILL_W'(g) < fill_reg),
                .left_key     (left_key),
                .left_greater (left_greater),
                .right_key    (right_key),
                .key          (keys[g]),
                .greater      (greater[g])
            );
        end
    endgenerate

    always_comb begin
        state_next    = state_reg;
        clock_next    = clock_reg;
        count_next    = count_reg;
        fill_next     = fill_reg;
        ctrl          = '0;
        m_valid_next  = m_valid_reg && !m_tready;
        m_action_next = m_action_reg;
        m_ts_next     = m_ts_reg;
        m_port_next   = m_port_reg;
        m_ovf_next    = m_ovf_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (cmd_reg)
                    CMD_LOCAL, CMD_PEER: begin
                        if (out_free) begin
                            clock_next    = clk_inc;
                            ctrl.insert   = !full;
                            fill_next     = full ? fill_reg : fill_reg + 1'b1;
                            m_valid_next  = 1'b1;
                            m_action_next = (cmd_reg == CMD_LOCAL) ? ACT_BROADCAST
                                                                   : ACT_REPLY;
                            m_ts_next     = clk_inc;
                            m_port_next   = (cmd_reg == CMD_LOCAL) ? own_port_reg
                                                                   : port_reg;
                            m_ovf_next    = full;
                            state_next    = ST_IDLE;
                        end
                    end
                    CMD_REPLY: begin
                        if (port_reg == own_port_reg) begin
                            count_next = (count_reg == COUNT_MAX) ? count_reg
                                                                  : count_reg + 1'b1;
                            state_next = ST_GRANT;
                        end else if (out_free) begin
                            m_valid_next  = 1'b1;
                            m_action_next = ACT_NONE;
                            m_ts_next     = '0;
                            m_port_next   = '0;
                            m_ovf_next    = 1'b0;
                            state_next    = ST_IDLE;
                        end
                    end
                    default: begin
                        ctrl.pop   = (fill_reg != '0);
                        fill_next  = (fill_reg != '0) ? fill_reg - 1'b1 : fill_reg;
                        state_next = ST_GRANT;
                    end
                endcase
            end
            ST_GRANT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_ovf_next   = 1'b0;
                    if (granted) begin
                        ctrl.pop      = 1'b1;
                        fill_next     = fill_reg - 1'b1;
                        count_next    = '0;
                        m_action_next = ACT_ENTER;
                        m_ts_next     = keys[0][KEY_W-1:PORT_W];
                        m_port_next   = own_port_reg;
                    end else begin
                        m_action_next = ACT_NONE;
                        m_ts_next     = '0;
                        m_port_next   = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            clock_reg      <= '0;
            count_reg      <= '0;
            fill_reg       <= '0;
            m_valid_reg    <= 1'b0;
            own_port_reg   <= '0;
            peer_count_reg <= CNT_W'(1);
        end else begin
            state_reg   <= state_next;
            clock_reg   <= clock_next;
            count_reg   <= count_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_OWN_PORT:   own_port_reg   <= cfg_wdata[PORT_W-1:0];
                    REG_PEER_COUNT: peer_count_reg <= cfg_wdata[CNT_W-1:0];
                    default:        own_port_reg   <= own_port_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg  <= s_tuser;
            ts_reg   <= s_tdata[TS_W-1:0];
            port_reg <= s_tdata[TS_W+PORT_W-1:TS_W];
        end
        m_action_reg <= m_action_next;
        m_ts_reg     <= m_ts_next;
        m_port_reg   <= m_port_next;
        m_ovf_reg    <= m_ovf_next;
    end

endmodule

### tb/tb_lamport_mutex_node.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lamport_mutex_node
// Self-checking bench for one Lamport mutual exclusion node. A short table of
// words covers reset behavior, grants, empty and full queue. Random phases
// follow, with varied node port, quorum and stream back-pressure. A shadow of
// the clock, reply count and sorted request queue predicts each result word not
// fixed by the table, and the m_ stream is checked in order against it.
// ----------------------------------------------------------------------------
module tb_lamport_mutex_node;
    import lmx_pkg::*;

    localparam int QDEPTH  = QUEUE_DEPTH_DEF;
    localparam int LATENCY = 3;
    localparam int N_ROWS  = 30;
    localparam int N_FIRST = 26;

    typedef struct packed {
        logic [1:0]  action;
        logic [30:0] ts;
        logic [15:0] port;
        logic        ovf;
    } result_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [30:0] ts;
        logic [15:0] port;
        logic        fixed;
        result_t     want;
    } stim_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;
    logic                 cfg_we;
    logic                 cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    logic                 fixed_row;
    result_t              fixed_want;

    // shadow node state
    logic [30:0]          lam_clock;
    logic [7:0]           ack_count;
    key_t                 req_q [QDEPTH];
    int                   req_fill;
    logic [15:0]          node_port;
    logic [7:0]           quorum;

    result_t              expected_actions [$];
    stim_row_t            dir_tab [N_ROWS];
    int                   errors = 0;
    int                   send_idle_pct = 0;
    int                   stall_pct = 0;

    lamport_mutex_node uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    function automatic logic [30:0] tick(input logic [30:0] v);
        return (v == CLOCK_MAX) ? v : v + 31'd1;
    endfunction

    function automatic bit req_insert(input key_t k);
        int pos;
        if (req_fill >= QDEPTH) return 1'b0;
        pos = 0;
        while (pos < req_fill && req_q[pos] <= k) pos++;
        for (int i = req_fill; i > pos; i--) req_q[i] = req_q[i-1];
        req_q[pos] = k;
        req_fill++;
        return 1'b1;
    endfunction

    function automatic void req_pop();
        if (req_fill == 0) return;
        for (int i = 1; i < req_fill; i++) req_q[i-1] = req_q[i];
        req_fill--;
    endfunction

    function automatic result_t enter_check();
        result_t r;
        key_t    head;
        r = '0;
        if (req_fill == 0 || ack_count != quorum) return r;
        head = req_q[0];
        if (head[15:0] != node_port) return r;
        req_pop();
        ack_count = 8'd0;
        r.action = ACT_ENTER;
        r.ts     = head[KEY_W-1:16];
        r.port   = node_port;
        return r;
    endfunction

    function automatic result_t next_action(input logic [1:0] cmd, input logic [30:0] ts,
                                            input logic [15:0] port);
        result_t r;
        r = '0;
        case (cmd)
            CMD_LOCAL: begin
                lam_clock = tick(lam_clock);
                r.ovf    = !req_insert({lam_clock, node_port});
                r.action = ACT_BROADCAST;
                r.ts     = lam_clock;
                r.port   = node_port;
            end
            CMD_PEER: begin
                lam_clock = tick((lam_clock > ts) ? lam_clock : ts);
                r.ovf    = !req_insert({ts, port});
                r.action = ACT_REPLY;
                r.ts     = lam_clock;
                r.port   = port;
            end
            CMD_REPLY: begin
                if (port == node_port) begin
                    if (ack_count != COUNT_MAX) ack_count = ack_count + 8'd1;
                    r = enter_check();
                end
            end
            default: begin
                req_pop();
                r = enter_check();
            end
        endcase
        return r;
    endfunction

    function automatic stim_row_t mk(input logic [1:0] c, input logic [30:0] t,
                                     input logic [15:0] p, input logic f, input result_t w);
        stim_row_t row;
        row.cmd   = c;
        row.ts    = t;
        row.port  = p;
        row.fixed = f;
        row.want  = w;
        return row;
    endfunction

    always @(posedge aclk) begin
        m_tready <= aresetn && ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge aclk) begin
        result_t want;
        result_t got;
        if (!aresetn) begin
            lam_clock = '0;
            ack_count = '0;
            req_fill  = 0;
            node_port = '0;
            quorum    = 8'd1;
        end else begin
            if (s_tvalid && s_tready) begin
                want = next_action(s_tuser, s_tdata[30:0], s_tdata[46:31]);
                if (fixed_row) want = fixed_want;
                expected_actions = {expected_actions, want};
            end
            if (m_tvalid && m_tready) begin
                got.action = m_tuser;
                got.ts     = m_tdata[30:0];
                got.port   = m_tdata[46:31];
                got.ovf    = m_tdata[47];
                if (expected_actions.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected word: act %0d ts %h port %h ovf %b",
                                 got.action, got.ts, got.port, got.ovf);
                end else begin
                    want = expected_actions.pop_front();
                    if (got.action !== want.action || got.ts !== want.ts ||
                        got.port !== want.port || got.ovf !== want.ovf) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp %0d %h %h %b, got %0d %h %h %b",
                                     want.action, want.ts, want.port, want.ovf,
                                     got.action, got.ts, got.port, got.ovf);
                    end
                end
            end
        end
    end

    task automatic send_word(input logic [1:0] cmd, input logic [30:0] ts,
                             input logic [15:0] port, input logic fixed, input result_t want);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= {1'b0, port, ts};
        s_tuser    <= cmd;
        fixed_row  <= fixed;
        fixed_want <= want;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_actions.size() != 0) @(posedge aclk);
        repeat (2 * LATENCY) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
        if (idx == REG_OWN_PORT) node_port = val;
        else quorum = val[7:0];
    endtask

    task automatic run_rows(input int first, input int last);
        for (int i = first; i <= last; i++)
            send_word(dir_tab[i].cmd, dir_tab[i].ts, dir_tab[i].port,
                      dir_tab[i].fixed, dir_tab[i].want);
    endtask

    task automatic random_word();
        int          pick;
        int          d;
        longint      t;
        logic [31:0] rnd;
        logic [1:0]  c;
        logic [30:0] ts;
        logic [15:0] p;
        pick = $urandom_range(0, 99);
        rnd  = $urandom;
        ts   = rnd[30:0];
        rnd  = $urandom;
        p    = rnd[15:0];
        if (pick < 12) begin
            c = CMD_LOCAL;
        end else if (pick < 30) begin
            c = CMD_PEER;
            if ($urandom_range(0, 9) != 0) begin
                d = $urandom_range(0, 6);
                t = longint'(lam_clock) + d - 3;
                if (t < 0) t = 0;
                if (t > longint'(CLOCK_MAX)) t = longint'(CLOCK_MAX);
                ts = t[30:0];
            end
            if ($urandom_range(0, 3) != 0)
                p = 16'(32'h4000 * $urandom_range(0, 3) + 32'h0011);
        end else if (pick < 60) begin
            c = CMD_REPLY;
            p = node_port;
        end else if (pick < 65) begin
            c = CMD_REPLY;
        end else if (pick < 95) begin
            c = CMD_RELEASE;
        end else begin
            rnd = $urandom;
            c   = rnd[1:0];
        end
        send_word(c, ts, p, 1'b0, '0);
    endtask

    task automatic run_phase(input logic [15:0] node, input logic [7:0] need,
                             input int sidle, input int rstall, input int count);
        drain();
        write_reg(REG_OWN_PORT, node);
        write_reg(REG_PEER_COUNT, {8'h00, need});
        send_idle_pct = sidle;
        stall_pct     = rstall;
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) drain();
            random_word();
        end
    endtask

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        aresetn    <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= CMD_LOCAL;
        cfg_we     <= 1'b0;
        cfg_index  <= REG_OWN_PORT;
        cfg_wdata  <= '0;
        fixed_row  <= 1'b0;
        fixed_want <= '0;

        dir_tab[0] = mk(CMD_LOCAL,   31'h7FFFFFFF, 16'hFFFF, 1'b1,
                        result_t'{ACT_BROADCAST, 31'd1, 16'h0000, 1'b0});
        dir_tab[1] = mk(CMD_REPLY,   31'h0, 16'hFFFF, 1'b1, result_t'{ACT_NONE, 31'd0, 16'h0, 1'b0});
        dir_tab[2] = mk(CMD_REPLY,   31'h0, 16'h0000, 1'b1,
                        result_t'{ACT_ENTER, 31'd1, 16'h0000, 1'b0});
        dir_tab[3] = mk(CMD_REPLY,   31'h0, 16'h0000, 1'b1, result_t'{ACT_NONE, 31'd0, 16'h0, 1'b0});
        dir_tab[4] = mk(CMD_RELEASE, 31'h0, 16'h0000, 1'b1, result_t'{ACT_NONE, 31'd0, 16'h0, 1'b0});
        dir_tab[5] = mk(CMD_PEER,    31'h0, 16'h5555, 1'b1,
                        result_t'{ACT_REPLY, 31'd2, 16'h5555, 1'b0});
        dir_tab[6] = mk(CMD_LOCAL,   31'h2AAAAAAA, 16'hAAAA, 1'b1,
                        result_t'{ACT_BROADCAST, 31'd3, 16'h0000, 1'b0});
        dir_tab[7] = mk(CMD_RELEASE, 31'h55555555, 16'h5555, 1'b0, '0);
        for (int i = 0; i < QDEPTH; i++)
            dir_tab[8+i] = mk(CMD_PEER,
                              (i < 8) ? 31'(i * 3) : 31'h2AAAAAAA + 31'(i / 4),
                              (i < 8 && (i % 2) == 1) ? 16'hAAAA : 16'h5555, 1'b0, '0);
        dir_tab[24] = mk(CMD_LOCAL,   31'h0, 16'h0, 1'b0, '0);
        dir_tab[25] = mk(CMD_PEER,    31'h1, 16'h0001, 1'b0, '0);
        dir_tab[26] = mk(CMD_PEER,    31'h7FFFFFFF, 16'hFFFF, 1'b0, '0);
        dir_tab[27] = mk(CMD_LOCAL,   31'h0, 16'h0, 1'b0, '0);
        dir_tab[28] = mk(CMD_LOCAL,   31'h0, 16'h0, 1'b0, '0);
        dir_tab[29] = mk(CMD_PEER,    31'h7FFFFFFE, 16'h0000, 1'b0, '0);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_rows(0, N_FIRST - 1);

        run_phase(16'hFFFF, 8'd1, 0, 0, 220);
        run_phase(16'($urandom), 8'd2, 67, 0, 220);
        run_phase(16'($urandom), 8'd3, 0, 67, 220);
        run_phase(16'($urandom), 8'($urandom_range(1, 4)), 24, 24, 220);

        // saturate the reply count behind a foreign head
        drain();
        write_reg(REG_OWN_PORT, 16'h1234);
        write_reg(REG_PEER_COUNT, 16'd255);
        send_word(CMD_PEER, 31'd0, 16'h0000, 1'b0, '0);
        repeat (300) send_word(CMD_REPLY, 31'($urandom), 16'h1234, 1'b0, '0);
        send_word(CMD_RELEASE, 31'($urandom), 16'($urandom), 1'b0, '0);
        repeat (40) random_word();

        run_phase(16'h00FF, 8'd0, 0, 0, 60);

        drain();
        write_reg(REG_OWN_PORT, 16'h0000);
        write_reg(REG_PEER_COUNT, 16'd1);
        run_rows(N_FIRST, N_ROWS - 1);

        drain();
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
